[rtl/detector_event_histogrammer_defines.svh]
// Assertion macros for the checker file of the event histogrammer.
// No dependencies; included by name where assertions are written.
`ifndef DETECTOR_EVENT_HISTOGRAMMER_DEFINES_SVH
`define DETECTOR_EVENT_HISTOGRAMMER_DEFINES_SVH

// same-cycle implication
`define DEH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DEH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/deh_pkg.sv]
// Types, codes and reset values of the detector event histogrammer.
// No dependencies; imported by every module of the block.
package deh_pkg;

    // action codes of an input word
    localparam logic [1:0] ACT_LOAD     = 2'd0;
    localparam logic [1:0] ACT_EVENT    = 2'd1;
    localparam logic [1:0] ACT_READ     = 2'd2;
    localparam logic [1:0] ACT_READ_CLR = 2'd3;

    // result status codes
    localparam logic [2:0] ST_COUNTED  = 3'd0;
    localparam logic [2:0] ST_IGNORED  = 3'd1;
    localparam logic [2:0] ST_UNMAPPED = 3'd2;
    localparam logic [2:0] ST_OOR      = 3'd3;
    localparam logic [2:0] ST_LOADED   = 3'd4;
    localparam logic [2:0] ST_READ     = 3'd5;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_X_ORIGIN   = 3'd0;
    localparam logic [2:0] REG_X_RATE     = 3'd1;
    localparam logic [2:0] REG_Y_ORIGIN   = 3'd2;
    localparam logic [2:0] REG_Y_RATE     = 3'd3;
    localparam logic [2:0] REG_BINS_X     = 3'd4;
    localparam logic [2:0] REG_BINS_Y     = 3'd5;
    localparam logic [2:0] REG_TUBE_LIMIT = 3'd6;

    localparam int QUEUE_DEPTH = 4;
    // histogram address wide enough for 1024 x 1024 bins
    localparam int HIST_ADDR_W = 20;

    typedef struct packed {
        logic [1:0]         action;
        logic [7:0]         tube_id;
        logic [11:0]        raw_value;
        logic signed [31:0] map_position_x;
        logic [15:0]        map_scale_y;
        logic [7:0]         read_bin_x;
        logic [7:0]         read_bin_y;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  bin_x;
        logic [7:0]  bin_y;
        logic [31:0] count;
    } t_out;

    typedef struct packed {
        logic [31:0] x_origin;
        logic [31:0] x_bins_per_metre;
        logic [31:0] y_origin;
        logic [31:0] y_bins_per_metre;
        logic [8:0]  bins_in_x;
        logic [8:0]  bins_in_y;
        logic [8:0]  tube_limit;
    } t_cfg;

    localparam t_cfg CFG_RST = '{
        x_origin:         32'hFFFF_7989,   // -34423
        x_bins_per_metre: 32'd12227606,
        y_origin:         32'hFFFF_7A1C,   // -34276
        y_bins_per_metre: 32'd16039213,
        bins_in_x:        9'd196,
        bins_in_y:        9'd256,
        tube_limit:       9'd196
    };

    typedef enum logic [1:0] {
        OP_PASS,
        OP_COUNT,
        OP_READ,
        OP_READ_CLR
    } t_op;

    // classified word handed from front to back
    typedef struct packed {
        t_op                    op;
        logic [2:0]             status;
        logic [7:0]             bin_x;
        logic [7:0]             bin_y;
        logic [HIST_ADDR_W-1:0] addr;
    } t_job;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

endpackage

[rtl/deh_fifo.sv]
// Short job queue between the front and back halves.
// Depends on deh_pkg (t_job, QUEUE_DEPTH).
module deh_fifo import deh_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_head,
    output logic o_empty
);
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job           r_q [QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_cnt;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

[rtl/deh_front.sv]
// Front half: takes input words, holds the tube map and bins each event.
// Depends on deh_pkg; feeds jobs into deh_fifo.
module deh_front import deh_pkg::*; #(
    parameter int MAP_DEPTH  = 256,
    parameter int MAX_BINS_X = 256,
    parameter int MAX_BINS_Y = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_back_stat i_back,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in_data,
    output logic       o_push,
    output t_job       o_push_job,
    input  logic       i_q_full
);
    localparam int MW  = (MAP_DEPTH > 1)  ? $clog2(MAP_DEPTH)  : 1;
    localparam int BXW = (MAX_BINS_X > 1) ? $clog2(MAX_BINS_X) : 1;
    localparam int BYW = (MAX_BINS_Y > 1) ? $clog2(MAX_BINS_Y) : 1;
    localparam logic [31:0] MAXX = 32'(MAX_BINS_X);
    localparam logic [31:0] MAXY = 32'(MAX_BINS_Y);

    // tube map
    logic [MAP_DEPTH-1:0] r_tube_valid;
    logic [31:0]          r_map_x     [MAP_DEPTH];
    logic [15:0]          r_map_scale [MAP_DEPTH];

    logic          en, accept, in_map;
    logic [MW-1:0] map_idx;

    // stage 1: word and map entry
    logic        r1_v, r1_tube_ok;
    t_in         r1_item;
    logic [31:0] r1_map_x;
    logic [15:0] r1_map_scale;
    // stage 2: x offset, y position
    logic              r2_v, r2_pend;
    t_job              r2_job;
    logic signed [32:0] r2_dx;
    logic [27:0]       r2_ypos;
    // stage 3: x bin, y offset
    logic              r3_v, r3_pend, r3_dx_neg;
    t_job              r3_job;
    logic [31:0]       r3_bx_hi;
    logic signed [32:0] r3_dy;
    // stage 4: y bin
    logic              r4_v, r4_pend, r4_x_bad, r4_dy_neg;
    t_job              r4_job;
    logic [BXW-1:0]    r4_bx;
    logic [31:0]       r4_by_hi;

    t_job               s1_job;
    logic               s1_pend, ignored, rd_oor;
    logic signed [32:0] s1_dx, s2_dy;
    logic [27:0]        s1_ypos;
    logic [63:0]        prod_x, prod_y;
    logic [31:0]        lim_x, lim_y;
    logic               y_bad;
    logic [BYW-1:0]     s4_by;

    // whole pipe moves unless the last stage is blocked by a full queue
    assign en         = !(r4_v && i_q_full);
    assign o_in_ready = en && !i_back.clearing;
    assign accept     = i_in_valid && o_in_ready;
    assign map_idx    = MW'(i_in_data.tube_id);
    assign in_map     = (32'(i_in_data.tube_id) < 32'(MAP_DEPTH));

    assign lim_x = (32'(i_cfg.bins_in_x) > MAXX) ? MAXX : 32'(i_cfg.bins_in_x);
    assign lim_y = (32'(i_cfg.bins_in_y) > MAXY) ? MAXY : 32'(i_cfg.bins_in_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tube_valid <= '0;
        end else if (accept && i_in_data.action == ACT_LOAD && in_map) begin
            r_tube_valid[map_idx] <= 1'b1;
        end
    end

    // map store: write on load, registered read on every accepted word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (i_in_data.action == ACT_LOAD && in_map) begin
                r_map_x[map_idx]     <= i_in_data.map_position_x;
                r_map_scale[map_idx] <= i_in_data.map_scale_y;
            end
            r1_map_x     <= r_map_x[map_idx];
            r1_map_scale <= r_map_scale[map_idx];
            r1_tube_ok   <= in_map && r_tube_valid[map_idx];
        end
    end

    // stage 1 classification
    assign ignored = ({1'b0, r1_item.tube_id} >= i_cfg.tube_limit);
    assign rd_oor  = (32'(r1_item.read_bin_x) >= MAXX) || (32'(r1_item.read_bin_y) >= MAXY);
    assign s1_ypos = 28'(r1_item.raw_value) * 28'(r1_map_scale);
    assign s1_dx   = $signed({r1_map_x[31], r1_map_x})
                   - $signed({i_cfg.x_origin[31], i_cfg.x_origin});

    always_comb begin
        s1_job  = '0;
        s1_pend = 1'b0;
        case (r1_item.action)
            ACT_LOAD: begin
                s1_job.op     = OP_PASS;
                s1_job.status = ST_LOADED;
            end
            ACT_EVENT: begin
                if (ignored) begin
                    s1_job.op     = OP_PASS;
                    s1_job.status = ST_IGNORED;
                end else if (!r1_tube_ok) begin
                    s1_job.op     = OP_PASS;
                    s1_job.status = ST_UNMAPPED;
                end else begin
                    s1_job.op     = OP_COUNT;
                    s1_job.status = ST_COUNTED;
                    s1_pend       = 1'b1;
                end
            end
            ACT_READ, ACT_READ_CLR: begin
                s1_job.bin_x = r1_item.read_bin_x;
                s1_job.bin_y = r1_item.read_bin_y;
                if (rd_oor) begin
                    s1_job.op     = OP_PASS;
                    s1_job.status = ST_OOR;
                end else begin
                    s1_job.op     = (r1_item.action == ACT_READ_CLR) ? OP_READ_CLR : OP_READ;
                    s1_job.status = ST_READ;
                    s1_job.addr   = HIST_ADDR_W'(r1_item.read_bin_y)
                                  * HIST_ADDR_W'(MAX_BINS_X)
                                  + HIST_ADDR_W'(r1_item.read_bin_x);
                end
            end
            default: begin
                s1_job.op     = OP_PASS;
                s1_job.status = ST_LOADED;
            end
        endcase
    end

    // stage 2: x product, y offset
    assign prod_x = 64'(r2_dx[31:0]) * 64'(i_cfg.x_bins_per_metre);
    assign s2_dy  = $signed({5'b0, r2_ypos}) - $signed({i_cfg.y_origin[31], i_cfg.y_origin});
    // stage 3: y product
    assign prod_y = 64'(r3_dy[31:0]) * 64'(i_cfg.y_bins_per_metre);
    // stage 4: y range and final job
    assign y_bad  = r4_dy_neg || (r4_by_hi >= lim_y);
    assign s4_by  = r4_by_hi[BYW-1:0];

    always_comb begin
        o_push_job = r4_job;
        if (r4_pend) begin
            if (r4_x_bad || y_bad) begin
                o_push_job        = '0;
                o_push_job.op     = OP_PASS;
                o_push_job.status = ST_OOR;
            end else begin
                o_push_job.bin_x = 8'(r4_bx);
                o_push_job.bin_y = 8'(s4_by);
                o_push_job.addr  = HIST_ADDR_W'(s4_by) * HIST_ADDR_W'(MAX_BINS_X)
                                 + HIST_ADDR_W'(r4_bx);
            end
        end
    end

    assign o_push = r4_v && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (en) begin
            r1_v <= accept;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_item   <= i_in_data;
            r2_job    <= s1_job;
            r2_pend   <= s1_pend;
            r2_dx     <= s1_dx;
            r2_ypos   <= s1_ypos;
            r3_job    <= r2_job;
            r3_pend   <= r2_pend;
            r3_dx_neg <= r2_dx[32];
            r3_bx_hi  <= prod_x[63:32];
            r3_dy     <= s2_dy;
            r4_job    <= r3_job;
            r4_pend   <= r3_pend;
            r4_x_bad  <= r3_dx_neg || (r3_bx_hi >= lim_x);
            r4_bx     <= r3_bx_hi[BXW-1:0];
            r4_dy_neg <= r3_dy[32];
            r4_by_hi  <= prod_y[63:32];
        end
    end

endmodule

[rtl/deh_back.sv]
// Back half: histogram store, clearing sweep, read-modify-write, result register.
// Depends on deh_pkg; pops jobs from deh_fifo.
module deh_back import deh_pkg::*; #(
    parameter int MAX_BINS_X  = 256,
    parameter int MAX_BINS_Y  = 256,
    parameter int COUNT_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_job       i_head,
    output logic       o_pop,
    output t_back_stat o_stat,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out_data
);
    localparam int HIST_DEPTH = MAX_BINS_X * MAX_BINS_Y;
    localparam int AW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_MOD   = 3'b100
    } t_state;

    t_state                 r_state, n_state;
    logic [AW-1:0]          r_clr_cnt, n_clr_cnt;
    logic [COUNT_WIDTH-1:0] r_hist [HIST_DEPTH];
    logic [COUNT_WIDTH-1:0] r_rd_data, wd, inc;
    t_job                   r_job, n_job;
    logic                   r_out_valid, n_out_valid;
    t_out                   r_out, n_out;
    logic                   we, re, out_free;
    logic [AW-1:0]          wa;

    // clamp a count to the 32-bit result field
    function automatic logic [31:0] sat32(input logic [COUNT_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (|w[63:32]) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    assign out_free    = !r_out_valid || i_out_ready;
    assign inc         = (&r_rd_data) ? r_rd_data : r_rd_data + 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_stat.clearing = (r_state == S_CLEAR);

    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_job       = r_job;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_pop       = 1'b0;
        we          = 1'b0;
        re          = 1'b0;
        wa          = r_job.addr[AW-1:0];
        wd          = '0;
        case (r_state)
            S_CLEAR: begin
                we        = 1'b1;
                wa        = r_clr_cnt;
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == AW'(HIST_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    re      = 1'b1;
                    n_job   = i_head;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out.status = r_job.status;
                    n_out.bin_x  = r_job.bin_x;
                    n_out.bin_y  = r_job.bin_y;
                    n_out.count  = '0;
                    case (r_job.op)
                        OP_COUNT: begin
                            we          = 1'b1;
                            wd          = inc;
                            n_out.count = sat32(inc);
                        end
                        OP_READ: begin
                            n_out.count = sat32(r_rd_data);
                        end
                        OP_READ_CLR: begin
                            we          = 1'b1;
                            n_out.count = sat32(r_rd_data);
                        end
                        default: begin
                            n_out.count = '0;
                        end
                    endcase
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_out <= n_out;
    end

    // histogram store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_hist[wa] <= wd;
        end
        if (re) begin
            r_rd_data <= r_hist[i_head.addr[AW-1:0]];
        end
    end

endmodule

[rtl/detector_event_histogrammer.sv]
// Top level of the detector event histogrammer: register file and the two halves.
// Depends on deh_pkg, deh_front, deh_fifo and deh_back.
//
// Usage
//   Input channel (i_in_valid / o_in_ready / i_in_data): one word per action:
//   load a tube map entry, count an event, read a bin, or read and clear it.
//   Output channel (o_out_valid / i_out_ready / o_out_data): exactly one
//   result word per input word, in input order.
//   Registers sit on the APB port at byte address 4*index; write them only
//   while the block is idle. pready is tied high.
// Data path and throughput
//   A result passes the front pipe, the queue, the histogram read and the
//   output register before it shows on o_out_valid. The back half takes a
//   new job only once the last is through: it reads the bin in S_IDLE, then
//   writes it back and loads the result register in S_MOD, then pops again.
//   The front half takes a word per cycle until the 4-entry queue fills.
// Reset
//   Synchronous, active low. Registers return to their defaults, the tube map
//   is marked empty, and the histogram is swept to zero one bin a cycle,
//   all MAX_BINS_X*MAX_BINS_Y bins (65536 by default), with o_in_ready low.
//   Register writes are taken during the sweep.
// Back-pressure
//   A stalled result holds in the output register; the back half then stops,
//   the queue fills, the front pipe freezes and o_in_ready drops.
module detector_event_histogrammer import deh_pkg::*; #(
    parameter int MAP_DEPTH   = 256,
    parameter int MAX_BINS_X  = 256,
    parameter int MAX_BINS_Y  = 256,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    // result words
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg       r_cfg, n_cfg;
    t_back_stat back_stat;
    logic       push, q_full, q_empty, pop, cfg_wr;
    t_job       push_job, head_job;

    // ---------------- register file ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            case (paddr[4:2])
                REG_X_ORIGIN:   n_cfg.x_origin         = pwdata;
                REG_X_RATE:     n_cfg.x_bins_per_metre = pwdata;
                REG_Y_ORIGIN:   n_cfg.y_origin         = pwdata;
                REG_Y_RATE:     n_cfg.y_bins_per_metre = pwdata;
                REG_BINS_X:     n_cfg.bins_in_x        = pwdata[8:0];
                REG_BINS_Y:     n_cfg.bins_in_y        = pwdata[8:0];
                REG_TUBE_LIMIT: n_cfg.tube_limit       = pwdata[8:0];
                default:        n_cfg = r_cfg;   // unused address, write dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // read-back, short registers zero-extended
    always_comb begin
        case (paddr[4:2])
            REG_X_ORIGIN:   prdata = r_cfg.x_origin;
            REG_X_RATE:     prdata = r_cfg.x_bins_per_metre;
            REG_Y_ORIGIN:   prdata = r_cfg.y_origin;
            REG_Y_RATE:     prdata = r_cfg.y_bins_per_metre;
            REG_BINS_X:     prdata = 32'(r_cfg.bins_in_x);
            REG_BINS_Y:     prdata = 32'(r_cfg.bins_in_y);
            REG_TUBE_LIMIT: prdata = 32'(r_cfg.tube_limit);
            default:        prdata = '0;
        endcase
    end

    // ---------------- front: map lookup and binning ----------------
    deh_front #(
        .MAP_DEPTH  (MAP_DEPTH),
        .MAX_BINS_X (MAX_BINS_X),
        .MAX_BINS_Y (MAX_BINS_Y)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_back     (back_stat),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_push     (push),
        .o_push_job (push_job),
        .i_q_full   (q_full)
    );

    // ---------------- job queue ----------------
    deh_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_head     (head_job),
        .o_empty    (q_empty)
    );

    // ---------------- back: histogram update and results ----------------
    deh_back #(
        .MAX_BINS_X  (MAX_BINS_X),
        .MAX_BINS_Y  (MAX_BINS_Y),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_head      (head_job),
        .o_pop       (pop),
        .o_stat      (back_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

[rtl/deh_port_checker.sv]
// Port-level checks on the event histogrammer, bound to the top level.
// Depends on deh_pkg and detector_event_histogrammer_defines.svh.
`include "detector_event_histogrammer_defines.svh"

module deh_port_checker import deh_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // a stalled result word holds
    `DEH_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result word dropped or changed while stalled")

    // the zeroing sweep follows every reset
    `DEH_ASSERT_NXT(a_sweep_after_rst, i_clk, 1'b1, !i_rst_n, !o_in_ready, "input taken straight after reset")

    // a counted event always leaves a non-zero count
    `DEH_ASSERT_IMP(a_count_nonzero, i_clk, i_rst_n, o_out_valid && o_out_data.status == ST_COUNTED, o_out_data.count != 32'd0, "counted bin reports zero")

    // rejected events and loads carry no bin and no count
    `DEH_ASSERT_IMP(a_reject_zero, i_clk, i_rst_n, o_out_valid && (o_out_data.status == ST_IGNORED || o_out_data.status == ST_UNMAPPED || o_out_data.status == ST_LOADED), o_out_data.bin_x == 8'd0 && o_out_data.bin_y == 8'd0 && o_out_data.count == 32'd0, "non-zero fields on a rejected word")

endmodule

bind detector_event_histogrammer deh_port_checker u_port_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

[tb/sv/detector_event_histogrammer_tb.sv]
// Self-checking testbench for the detector event histogrammer.
// Depends on deh_pkg and detector_event_histogrammer; an in-bench model predicts every result word.
`timescale 1ns / 100ps

module detector_event_histogrammer_tb;
    import deh_pkg::*;

    localparam int     MAP_DEPTH     = 256;
    localparam int     MAX_BINS      = 256;
    localparam int     SETTLE_CYCLES = 12;        // margin for the pipe to empty
    localparam int     CYCLE_LIMIT   = 1_000_000; // watchdog limit; the reset sweep counts towards it
    localparam longint POS_MIN       = -64'sd2147483648;
    localparam longint POS_MAX       = 64'sd2147483647;

    // receiver behaviour, picked anew each time a stall span runs out
    typedef enum logic [1:0] {
        RX_FREE,     // always ready
        RX_COIN,     // ready half the time
        RX_STARVED,  // ready one cycle in six on average
        RX_PULSED    // ready and stalled in alternate runs
    } t_rx_mode;

    // ---------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ---------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in         i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out_data;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [4:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    detector_event_histogrammer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // Model state: register copy, tube map, bin counts
    // ---------------------------------------------------------------------
    t_cfg               cfg;
    bit                 tube_loaded [MAP_DEPTH];
    logic signed [31:0] tube_pos    [MAP_DEPTH];
    logic [15:0]        tube_step   [MAP_DEPTH];
    logic [31:0]        bin_tally   [MAX_BINS*MAX_BINS];
    logic [15:0]        counted_bins[$];  // {y, x} of recent counted bins, for reads

    t_out        awaited_results[$];
    int unsigned cycle_count  = 0;
    int unsigned fail_count   = 0;
    int unsigned words_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned status_tally [6];
    int unsigned burst_left   = 0;

    t_rx_mode    stall_mode   = RX_FREE;
    int unsigned stall_span   = 0;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    task automatic clear_model();
        cfg = CFG_RST;
        foreach (tube_loaded[t]) tube_loaded[t] = 1'b0;
        foreach (tube_pos[t]) tube_pos[t] = '0;
        foreach (tube_step[t]) tube_step[t] = '0;
        foreach (bin_tally[k]) bin_tally[k] = '0;
        foreach (status_tally[s]) status_tally[s] = 0;
    endtask

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Q16 offset times Q16 bins/m, top 32 bits give the bin; false when outside [0, span)
    function automatic bit to_bin(input longint pos, input longint origin,
                                  input logic [31:0] rate, input logic [8:0] bin_total,
                                  output logic [7:0] bin);
        longint      offs;
        logic [63:0] uoffs;
        logic [63:0] prod;
        logic [63:0] span;
        bin  = '0;
        offs = pos - origin;
        span = (bin_total > MAX_BINS) ? MAX_BINS : bin_total;
        if (offs < 0) return 1'b0;
        uoffs = offs;
        prod  = uoffs * {32'b0, rate};   // offset below 2^32, so exact
        if (prod[63:32] >= span) return 1'b0;
        bin = prod[39:32];
        return 1'b1;
    endfunction

    // Expected result of one accepted word; updates map and counts as the block would.
    function automatic t_out histogram_outcome(input t_in w);
        t_out        r;
        logic [7:0]  bx;
        logic [7:0]  by;
        logic [15:0] bin_idx;
        longint      ypos;
        r = '0;
        case (w.action)
            ACT_LOAD: begin
                // tube_id is 8 bits, always inside the map
                tube_loaded[w.tube_id] = 1'b1;
                tube_pos[w.tube_id]    = w.map_position_x;
                tube_step[w.tube_id]   = w.map_scale_y;
                r.status = ST_LOADED;
            end
            ACT_EVENT: begin
                if (w.tube_id >= cfg.tube_limit) begin
                    r.status = ST_IGNORED;           // wins over unmapped
                end else if (!tube_loaded[w.tube_id]) begin
                    r.status = ST_UNMAPPED;
                end else begin
                    ypos = longint'(w.raw_value) * longint'(tube_step[w.tube_id]);
                    if (!to_bin(longint'(tube_pos[w.tube_id]), longint'($signed(cfg.x_origin)),
                                cfg.x_bins_per_metre, cfg.bins_in_x, bx) ||
                        !to_bin(ypos, longint'($signed(cfg.y_origin)),
                                cfg.y_bins_per_metre, cfg.bins_in_y, by)) begin
                        r.status = ST_OOR;
                    end else begin
                        bin_idx = {by, bx};
                        if (bin_tally[bin_idx] != '1) bin_tally[bin_idx] += 1;  // saturates
                        r.status = ST_COUNTED;
                        r.bin_x  = bx;
                        r.bin_y  = by;
                        r.count  = bin_tally[bin_idx];
                        counted_bins.insert(counted_bins.size(), bin_idx);
                        if (counted_bins.size() > 32) void'(counted_bins.pop_front());
                    end
                end
            end
            default: begin
                // read bins are 8 bits, so always inside storage
                bin_idx  = {w.read_bin_y, w.read_bin_x};
                r.status = ST_READ;
                r.bin_x  = w.read_bin_x;
                r.bin_y  = w.read_bin_y;
                r.count  = bin_tally[bin_idx];
                if (w.action == ACT_READ_CLR) bin_tally[bin_idx] = '0;
            end
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Word builders; unused fields carry random junk
    // ---------------------------------------------------------------------
    function automatic t_in junk_word();
        logic [95:0] bits;
        bits = {$urandom(), $urandom(), $urandom()};
        return t_in'(bits[$bits(t_in)-1:0]);
    endfunction

    function automatic t_in load_word(input logic [7:0] tube, input logic [31:0] pos,
                                      input logic [15:0] step);
        t_in w;
        w = junk_word();
        w.action         = ACT_LOAD;
        w.tube_id        = tube;
        w.map_position_x = pos;
        w.map_scale_y    = step;
        return w;
    endfunction

    function automatic t_in event_word(input logic [7:0] tube, input logic [11:0] raw);
        t_in w;
        w = junk_word();
        w.action    = ACT_EVENT;
        w.tube_id   = tube;
        w.raw_value = raw;
        return w;
    endfunction

    function automatic t_in read_word(input logic [1:0] act, input logic [7:0] bx,
                                      input logic [7:0] by);
        t_in w;
        w = junk_word();
        w.action     = act;
        w.read_bin_x = bx;
        w.read_bin_y = by;
        return w;
    endfunction

    // Q16 extent of the image along one axis; a zero rate puts everything in bin 0
    function automatic longint coord_reach(input logic [31:0] rate,
                                           input logic [8:0] bin_total);
        longint span;
        span = (bin_total > MAX_BINS) ? MAX_BINS : bin_total;
        if (rate == 0) return 64'sd1 << 33;
        return (span << 32) / longint'(rate);
    endfunction

    // Map entry that mostly lands inside the current image, with a little overshoot
    function automatic void aim_map_entry(output logic [31:0] px, output logic [15:0] sc);
        longint reach_x;
        longint reach_y;
        longint pos;
        longint top;
        reach_x = coord_reach(cfg.x_bins_per_metre, cfg.bins_in_x);
        reach_y = coord_reach(cfg.y_bins_per_metre, cfg.bins_in_y);
        pos = longint'($signed(cfg.x_origin)) + longint'($urandom_range(0,
                  32'(clip(reach_x + reach_x / 16, 0, 64'sd4294967295))));
        px  = 32'(clip(pos, POS_MIN, POS_MAX));
        top = longint'($signed(cfg.y_origin)) + reach_y;
        if (top < 0) sc = 16'($urandom);
        else         sc = 16'($urandom_range(0, 32'(clip(top / 4095, 0, 65535))));
        if ($urandom_range(0, 9) == 0) px = $urandom;
        if ($urandom_range(0, 9) == 0) sc = 16'($urandom);
    endfunction

    // ---------------------------------------------------------------------
    // Sender: bursts of random length, random gaps in between
    // ---------------------------------------------------------------------
    task automatic send_word(input t_in w);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        awaited_results.insert(awaited_results.size(), histogram_outcome(w));
        words_sent++;
    endtask

    // Drop valid, wait for every result, then let the pipe empty
    task automatic settle();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Receiver stall pattern, independent of the sender
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode <= t_rx_mode'($urandom_range(0, 3));
            stall_span <= $urandom_range(8, 160);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            RX_FREE:    i_out_ready <= 1'b1;
            RX_COIN:    i_out_ready <= 1'($urandom_range(0, 1));
            RX_STARVED: i_out_ready <= ($urandom_range(0, 5) == 0);
            default:    i_out_ready <= ~stall_span[2];
        endcase
    end

    // Result checker: each word against the oldest expectation
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (o_out_data.status <= ST_READ) status_tally[o_out_data.status]++;
            if (awaited_results.size() == 0) begin
                $error("result word with nothing expected, status %0d", o_out_data.status);
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                if (o_out_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_data.status);
                    fail_count++;
                end
                if (o_out_data.bin_x !== want.bin_x) begin
                    $error("bin_x: expected %0d, got %0d", want.bin_x, o_out_data.bin_x);
                    fail_count++;
                end
                if (o_out_data.bin_y !== want.bin_y) begin
                    $error("bin_y: expected %0d, got %0d", want.bin_y, o_out_data.bin_y);
                    fail_count++;
                end
                if (o_out_data.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, o_out_data.count);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Register port: setup cycle, access cycle, then idle between writes
    // ---------------------------------------------------------------------
    task automatic write_register(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_X_ORIGIN:   cfg.x_origin         = val;
            REG_X_RATE:     cfg.x_bins_per_metre = val;
            REG_Y_ORIGIN:   cfg.y_origin         = val;
            REG_Y_RATE:     cfg.y_bins_per_metre = val;
            REG_BINS_X:     cfg.bins_in_x        = val[8:0];
            REG_BINS_Y:     cfg.bins_in_y        = val[8:0];
            REG_TUBE_LIMIT: cfg.tube_limit       = val[8:0];
            default: ;
        endcase
    endtask

    task automatic apply_setup(input t_cfg c);
        write_register(REG_X_ORIGIN,   c.x_origin);
        write_register(REG_X_RATE,     c.x_bins_per_metre);
        write_register(REG_Y_ORIGIN,   c.y_origin);
        write_register(REG_Y_RATE,     c.y_bins_per_metre);
        write_register(REG_BINS_X,     {23'b0, c.bins_in_x});
        write_register(REG_BINS_Y,     {23'b0, c.bins_in_y});
        write_register(REG_TUBE_LIMIT, {23'b0, c.tube_limit});
    endtask

    // ---------------------------------------------------------------------
    // Random traffic: load a window of tubes under the limit, then a mix of
    // aimed loads, events on those tubes, reads of counted bins and noise
    // ---------------------------------------------------------------------
    task automatic run_traffic(input int n_words);
        t_in         w;
        int unsigned lim;
        int unsigned hi;
        int unsigned lo;
        int unsigned pick;
        logic [15:0] b;
        lim = (cfg.tube_limit > MAP_DEPTH) ? MAP_DEPTH : cfg.tube_limit;
        hi  = (lim == 0) ? MAP_DEPTH - 1 : lim - 1;
        lo  = (hi > 23) ? hi - 23 : 0;
        for (int unsigned t = lo; t <= hi; t++) begin
            w = load_word(8'(t), '0, '0);
            aim_map_entry(w.map_position_x, w.map_scale_y);
            send_word(w);
        end
        repeat (n_words) begin
            w    = junk_word();
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // noise: every field random
            end else if (pick < 18) begin
                w.action  = ACT_LOAD;
                w.tube_id = 8'($urandom_range(lo, hi));
                aim_map_entry(w.map_position_x, w.map_scale_y);
            end else if (pick < 70) begin
                w.action  = ACT_EVENT;
                if ($urandom_range(0, 99) < 85) w.tube_id = 8'($urandom_range(lo, hi));
            end else begin
                w.action = (pick < 86) ? ACT_READ : ACT_READ_CLR;
                if (counted_bins.size() != 0 && $urandom_range(0, 9) < 7) begin
                    b = counted_bins[$urandom_range(0, counted_bins.size() - 1)];
                    w.read_bin_x = b[7:0];
                    w.read_bin_y = b[15:8];
                end
            end
            send_word(w);
        end
        settle();
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Defaults after reset: unmapped and ignored tubes, map extremes, both
    // out-of-range directions, reads and read-and-clear, map overwrite.
    task automatic test_map_and_special_cases();
        logic [15:0] b;
        send_word(event_word(8'd5, 12'd100));               // nothing loaded yet
        send_word(event_word(8'd200, 12'd0));               // ignored beats unmapped
        send_word(load_word(8'd0, 32'h0000_0000, 16'd16));
        send_word(load_word(8'd1, 32'h8000_0000, 16'hFFFF));
        send_word(load_word(8'd2, 32'h7FFF_FFFF, 16'd0));
        send_word(load_word(8'd195, 32'd16384, 16'd8));     // last tube under limit
        send_word(load_word(8'd255, 32'h0000_0000, 16'd16)); // stored, yet above limit
        send_word(event_word(8'd0, 12'd0));
        send_word(event_word(8'd0, 12'd0));
        b = counted_bins[counted_bins.size() - 1];
        send_word(event_word(8'd0, 12'hFFF));               // y beyond the top bin
        send_word(event_word(8'd1, 12'd7));                 // x below origin
        send_word(event_word(8'd2, 12'd0));                 // x beyond the last bin
        send_word(event_word(8'd255, 12'd0));               // mapped but ignored
        send_word(event_word(8'd195, 12'd2048));
        send_word(read_word(ACT_READ, b[7:0], b[15:8]));
        send_word(read_word(ACT_READ_CLR, b[7:0], b[15:8]));
        send_word(read_word(ACT_READ, b[7:0], b[15:8]));    // cleared to zero
        send_word(read_word(ACT_READ_CLR, 8'd0, 8'd0));
        send_word(read_word(ACT_READ, 8'hFF, 8'hFF));
        send_word(load_word(8'd0, 32'hFFFF_B1E0, 16'd1));   // overwrite an entry
        send_word(event_word(8'd0, 12'd4095));
        settle();
    endtask

    task automatic test_default_geometry();
        run_traffic(300);
    endtask

    // Full 256 x 256 image, every tube accepted
    task automatic test_fine_square_image();
        apply_setup('{x_origin: 32'd0, x_bins_per_metre: 32'h0010_0000,
                      y_origin: 32'd0, y_bins_per_metre: 32'h0010_0000,
                      bins_in_x: 9'd256, bins_in_y: 9'd256, tube_limit: 9'd256});
        run_traffic(360);
    endtask

    // One bin each way, one tube, lowest x origin and highest rates
    task automatic test_single_bin_extremes();
        apply_setup('{x_origin: 32'h8000_0000, x_bins_per_metre: 32'hFFFF_FFFF,
                      y_origin: 32'hFFFF_FFFF, y_bins_per_metre: 32'hFFFF_FFFF,
                      bins_in_x: 9'd1, bins_in_y: 9'd1, tube_limit: 9'd1});
        run_traffic(200);
    endtask

    // Zero rates fold every event at or above both origins into bin (0,0): deep counts
    task automatic test_collapsed_rates();
        apply_setup('{x_origin: 32'd0, x_bins_per_metre: 32'd0,
                      y_origin: 32'h8000_0000, y_bins_per_metre: 32'd0,
                      bins_in_x: 9'd256, bins_in_y: 9'd256, tube_limit: 9'd128});
        run_traffic(240);
    endtask

    task automatic test_all_tubes_ignored();
        apply_setup('{x_origin: 32'd0, x_bins_per_metre: 32'h0001_0000,
                      y_origin: 32'd0, y_bins_per_metre: 32'h0001_0000,
                      bins_in_x: 9'd16, bins_in_y: 9'd16, tube_limit: 9'd0});
        run_traffic(60);
    endtask

    // No x bins in use: every mapped event is out of range; highest y origin
    task automatic test_empty_image();
        apply_setup('{x_origin: 32'h7FFF_FFFF, x_bins_per_metre: 32'h8000_0000,
                      y_origin: 32'h7FFF_FFFF, y_bins_per_metre: 32'd1,
                      bins_in_x: 9'd0, bins_in_y: 9'd0, tube_limit: 9'd256});
        run_traffic(60);
    endtask

    task automatic test_mid_geometry();
        apply_setup('{x_origin: 32'hFFF0_0000, x_bins_per_metre: 32'h0003_0000,
                      y_origin: 32'hFFFF_F000, y_bins_per_metre: 32'h0040_0000,
                      bins_in_x: 9'd200, bins_in_y: 9'd128, tube_limit: 9'd100});
        run_traffic(380);
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial begin
        clear_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // the block sweeps its histogram after reset; o_in_ready holds the
        // first word back until that is done
        test_map_and_special_cases();
        test_default_geometry();
        test_fine_square_image();
        test_single_bin_extremes();
        test_collapsed_rates();
        test_all_tubes_ignored();
        test_empty_image();
        test_mid_geometry();
        $display("Covered %0d words over seven register settings: %0d counted, %0d ignored,",
                 words_sent, status_tally[ST_COUNTED], status_tally[ST_IGNORED]);
        $display("%0d unmapped, %0d out of range, %0d loads, %0d reads; %0d mismatches.",
                 status_tally[ST_UNMAPPED], status_tally[ST_OOR],
                 status_tally[ST_LOADED], status_tally[ST_READ], fail_count);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

endmodule
